[rtl/baro_second_order_compensation_macros.svh]
// Assertion macros shared by the checker of the barometric compensation block.
// No dependencies; include by bare file name.
`ifndef BARO_SECOND_ORDER_COMPENSATION_MACROS_SVH
`define BARO_SECOND_ORDER_COMPENSATION_MACROS_SVH

// Implication checked in the same cycle.
`define BSOC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define BSOC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bsoc_pkg.sv]
// Types and constants of the barometric second-order compensation block.
// No dependencies; used by every module of the block.
`default_nettype none

package bsoc_pkg;

    localparam int RAW_W   = 24;
    localparam int COEFF_W = 16;
    localparam int TERM_W  = 48;
    localparam int MUL_W   = 26;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int TEMP_W  = 19;
    localparam int PRES_W  = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_SENS_BASE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_BASE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SENS_TEMP   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_TEMP = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_REF_TEMP    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEMP_SLOPE  = 3'd5;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_RAW  = 2'd1;
    localparam logic [1:0] STATUS_NO_TERMS = 2'd2;

    localparam logic KIND_TEMP = 1'b0;
    localparam logic KIND_PRES = 1'b1;

    localparam logic [RAW_W-1:0] RAW_ALL_ONES = 24'hFFFFFF;

    localparam logic signed [20:0] TEMP_REF = 21'sd2000;
    localparam logic signed [20:0] TEMP_LOW = -21'sd1500;

    localparam logic signed [MUL_W-1:0] OFF2_F_SCALE = 26'sd61;
    localparam logic signed [MUL_W-1:0] OFF2_G_SCALE = 26'sd15;

    localparam int TEMP_SLOPE_SHIFT  = 23;
    localparam int OFFSET_TEMP_SHIFT = 6;
    localparam int SENS_TEMP_SHIFT   = 7;
    localparam int OFF2_SHIFT        = 4;
    localparam int SENS2_F_SHIFT     = 1;
    localparam int SENS2_G_SHIFT     = 3;
    localparam int T2_SHIFT          = 31;
    localparam int PRES_PROD_SHIFT   = 21;
    localparam int PRES_FINAL_SHIFT  = 15;
    localparam int SENS_SPLIT        = 24;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sh3FFFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 19'sh40000;
    localparam logic signed [PRES_W-1:0] PRES_MAX = 32'sh7FFFFFFF;
    localparam logic signed [PRES_W-1:0] PRES_MIN = 32'sh80000000;

    typedef struct packed {
        logic [COEFF_W-1:0] sens_base;
        logic [COEFF_W-1:0] offset_base;
        logic [COEFF_W-1:0] sens_temp;
        logic [COEFF_W-1:0] offset_temp;
        logic [COEFF_W-1:0] ref_temp;
        logic [COEFF_W-1:0] temp_slope;
    } cfg_t;

    typedef struct packed {
        logic                     sample_kind;
        logic [1:0]               status;
        logic signed [TEMP_W-1:0] temperature_centi;
        logic signed [PRES_W-1:0] pressure_pa;
    } res_t;

endpackage

`default_nettype wire

[rtl/bsoc_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on bsoc_pkg for the operand width.
`default_nettype none

module bsoc_mul (
    input  wire logic                                 aclk,
    input  wire logic signed [bsoc_pkg::MUL_W-1:0]    mul_a,
    input  wire logic signed [bsoc_pkg::MUL_W-1:0]    mul_b,
    output logic signed      [bsoc_pkg::PROD_W-1:0]   prod
);

    logic signed [bsoc_pkg::PROD_W-1:0] prod_reg;
    logic signed [bsoc_pkg::PROD_W-1:0] prod_next;

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[rtl/bsoc_core.sv]
// Sequencer and datapath of the compensation block: drives the shared multiplier,
// accumulates the terms and keeps the stored offset and sensitivity. Uses bsoc_pkg, bsoc_mul.
`default_nettype none

module bsoc_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_kind,
    input  wire logic [bsoc_pkg::RAW_W-1:0]    in_raw,
    input  wire bsoc_pkg::cfg_t                cfg,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output bsoc_pkg::res_t                     res
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHECK = 5'd1;
    localparam logic [4:0] S_T1    = 5'd2;
    localparam logic [4:0] S_T2    = 5'd3;
    localparam logic [4:0] S_T3    = 5'd4;
    localparam logic [4:0] S_T4    = 5'd5;
    localparam logic [4:0] S_T5    = 5'd6;
    localparam logic [4:0] S_T6    = 5'd7;
    localparam logic [4:0] S_T7    = 5'd8;
    localparam logic [4:0] S_T8    = 5'd9;
    localparam logic [4:0] S_T9    = 5'd10;
    localparam logic [4:0] S_T10   = 5'd11;
    localparam logic [4:0] S_T11   = 5'd12;
    localparam logic [4:0] S_TFIN  = 5'd13;
    localparam logic [4:0] S_P1    = 5'd14;
    localparam logic [4:0] S_P2    = 5'd15;
    localparam logic [4:0] S_P3    = 5'd16;
    localparam logic [4:0] S_P4    = 5'd17;
    localparam logic [4:0] S_P5    = 5'd18;
    localparam logic [4:0] S_OUT   = 5'd19;

    logic [4:0] step_reg, step_next;
    logic       kind_reg, kind_next;
    logic [bsoc_pkg::RAW_W-1:0] raw_reg, raw_next;
    logic signed [24:0] dt_reg, dt_next;
    logic signed [20:0] temp_reg, temp_next;
    logic [17:0]        t2_reg, t2_next;
    logic signed [bsoc_pkg::TERM_W-1:0] off_acc_reg, off_acc_next;
    logic signed [bsoc_pkg::TERM_W-1:0] sens_acc_reg, sens_acc_next;
    logic signed [bsoc_pkg::TERM_W-1:0] offset_term_reg, offset_term_next;
    logic signed [bsoc_pkg::TERM_W-1:0] sens_term_reg, sens_term_next;
    logic       terms_valid_reg, terms_valid_next;
    logic signed [71:0] pacc_reg, pacc_next;
    logic signed [52:0] x_reg, x_next;
    bsoc_pkg::res_t     res_reg, res_next;

    logic signed [bsoc_pkg::MUL_W-1:0]  mul_a;
    logic signed [bsoc_pkg::MUL_W-1:0]  mul_b;
    logic signed [bsoc_pkg::PROD_W-1:0] prod;

    logic signed [bsoc_pkg::PROD_W-1:0] prod_sr_slope;
    logic signed [bsoc_pkg::PROD_W-1:0] prod_sr_off;
    logic signed [bsoc_pkg::PROD_W-1:0] prod_sr_sens;
    logic signed [bsoc_pkg::PROD_W-1:0] prod_sr_off2;
    logic signed [bsoc_pkg::PROD_W-1:0] prod_sl_f;
    logic signed [bsoc_pkg::PROD_W-1:0] prod_sl_g;
    logic signed [71:0] prod_ext;
    logic signed [71:0] prod_hi_shl;
    logic signed [71:0] pacc_sr;
    logic signed [52:0] pres_full;
    logic signed [20:0] d1;
    logic signed [20:0] d2;
    logic signed [21:0] temp_full;
    logic signed [bsoc_pkg::MUL_W-1:0] dt_op;
    logic signed [bsoc_pkg::MUL_W-1:0] d1_op;
    logic signed [bsoc_pkg::MUL_W-1:0] d2_op;
    logic signed [bsoc_pkg::MUL_W-1:0] prod_op;
    logic signed [bsoc_pkg::MUL_W-1:0] raw_op;
    logic signed [bsoc_pkg::MUL_W-1:0] sens_lo_op;
    logic signed [bsoc_pkg::MUL_W-1:0] sens_hi_op;
    logic raw_bad;

    bsoc_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    assign prod_sr_slope = prod >>> bsoc_pkg::TEMP_SLOPE_SHIFT;
    assign prod_sr_off   = prod >>> bsoc_pkg::OFFSET_TEMP_SHIFT;
    assign prod_sr_sens  = prod >>> bsoc_pkg::SENS_TEMP_SHIFT;
    assign prod_sr_off2  = prod >>> bsoc_pkg::OFF2_SHIFT;
    assign prod_sl_f     = prod <<< bsoc_pkg::SENS2_F_SHIFT;
    assign prod_sl_g     = prod <<< bsoc_pkg::SENS2_G_SHIFT;
    assign prod_ext      = signed'({{20{prod[bsoc_pkg::PROD_W-1]}}, prod});
    assign prod_hi_shl   = prod_ext <<< bsoc_pkg::SENS_SPLIT;
    assign pacc_sr       = pacc_reg >>> bsoc_pkg::PRES_PROD_SHIFT;
    assign pres_full     = x_reg >>> bsoc_pkg::PRES_FINAL_SHIFT;

    assign d1 = temp_reg - bsoc_pkg::TEMP_REF;
    assign d2 = temp_reg - bsoc_pkg::TEMP_LOW;
    assign temp_full = signed'({temp_reg[20], temp_reg}) - signed'({4'b0, t2_reg});

    assign dt_op      = signed'({dt_reg[24], dt_reg});
    assign d1_op      = signed'({{5{d1[20]}}, d1});
    assign d2_op      = signed'({{5{d2[20]}}, d2});
    assign prod_op    = signed'(prod[bsoc_pkg::MUL_W-1:0]);
    assign raw_op     = signed'({2'b0, raw_reg});
    assign sens_lo_op = signed'({2'b0, sens_term_reg[23:0]});
    assign sens_hi_op = signed'({{2{sens_term_reg[47]}}, sens_term_reg[47:24]});

    assign raw_bad = (raw_reg == '0) || (raw_reg == bsoc_pkg::RAW_ALL_ONES);

    always_comb begin
        step_next        = step_reg;
        kind_next        = kind_reg;
        raw_next         = raw_reg;
        dt_next          = dt_reg;
        temp_next        = temp_reg;
        t2_next          = t2_reg;
        off_acc_next     = off_acc_reg;
        sens_acc_next    = sens_acc_reg;
        offset_term_next = offset_term_reg;
        sens_term_next   = sens_term_reg;
        terms_valid_next = terms_valid_reg;
        pacc_next        = pacc_reg;
        x_next           = x_reg;
        res_next         = res_reg;
        mul_a            = '0;
        mul_b            = '0;

        case (step_reg)
            S_IDLE: begin
                if (in_valid) begin
                    kind_next = in_kind;
                    raw_next  = in_raw;
                    step_next = S_CHECK;
                end
            end
            S_CHECK: begin
                res_next.sample_kind       = kind_reg;
                res_next.status            = bsoc_pkg::STATUS_OK;
                res_next.temperature_centi = '0;
                res_next.pressure_pa       = '0;
                t2_next = '0;
                dt_next = signed'({1'b0, raw_reg}) - signed'({1'b0, cfg.ref_temp, 8'b0});
                if (raw_bad) begin
                    res_next.status = bsoc_pkg::STATUS_BAD_RAW;
                    if (kind_reg == bsoc_pkg::KIND_TEMP) begin
                        offset_term_next = '0;
                        sens_term_next   = '0;
                        terms_valid_next = 1'b0;
                    end
                    step_next = S_OUT;
                end else if (kind_reg == bsoc_pkg::KIND_TEMP) begin
                    step_next = S_T1;
                end else if (!terms_valid_reg) begin
                    res_next.status = bsoc_pkg::STATUS_NO_TERMS;
                    step_next = S_OUT;
                end else begin
                    step_next = S_P1;
                end
            end
            S_T1: begin
                mul_a     = dt_op;
                mul_b     = signed'({10'b0, cfg.temp_slope});
                step_next = S_T2;
            end
            S_T2: begin
                temp_next = bsoc_pkg::TEMP_REF + signed'(prod_sr_slope[20:0]);
                mul_a     = dt_op;
                mul_b     = signed'({10'b0, cfg.offset_temp});
                step_next = S_T3;
            end
            S_T3: begin
                off_acc_next = signed'({15'b0, cfg.offset_base, 17'b0})
                             + signed'(prod_sr_off[bsoc_pkg::TERM_W-1:0]);
                mul_a     = dt_op;
                mul_b     = signed'({10'b0, cfg.sens_temp});
                step_next = S_T4;
            end
            S_T4: begin
                sens_acc_next = signed'({16'b0, cfg.sens_base, 16'b0})
                              + signed'(prod_sr_sens[bsoc_pkg::TERM_W-1:0]);
                if (temp_reg < bsoc_pkg::TEMP_REF) begin
                    mul_a     = dt_op;
                    mul_b     = dt_op;
                    step_next = S_T5;
                end else begin
                    step_next = S_TFIN;
                end
            end
            S_T5: begin
                t2_next   = prod[48:bsoc_pkg::T2_SHIFT];
                mul_a     = d1_op;
                mul_b     = d1_op;
                step_next = S_T6;
            end
            S_T6: begin
                sens_acc_next = sens_acc_reg - signed'(prod_sl_f[bsoc_pkg::TERM_W-1:0]);
                mul_a     = d1_op;
                mul_b     = bsoc_pkg::OFF2_F_SCALE;
                step_next = S_T7;
            end
            S_T7: begin
                mul_a     = prod_op;
                mul_b     = d1_op;
                step_next = S_T8;
            end
            S_T8: begin
                off_acc_next = off_acc_reg - signed'(prod_sr_off2[bsoc_pkg::TERM_W-1:0]);
                if (temp_reg < bsoc_pkg::TEMP_LOW) begin
                    mul_a     = d2_op;
                    mul_b     = d2_op;
                    step_next = S_T9;
                end else begin
                    step_next = S_TFIN;
                end
            end
            S_T9: begin
                sens_acc_next = sens_acc_reg - signed'(prod_sl_g[bsoc_pkg::TERM_W-1:0]);
                mul_a     = d2_op;
                mul_b     = bsoc_pkg::OFF2_G_SCALE;
                step_next = S_T10;
            end
            S_T10: begin
                mul_a     = prod_op;
                mul_b     = d2_op;
                step_next = S_T11;
            end
            S_T11: begin
                off_acc_next = off_acc_reg - signed'(prod[bsoc_pkg::TERM_W-1:0]);
                step_next    = S_TFIN;
            end
            S_TFIN: begin
                if (!temp_full[21] && (temp_full[20:18] != 3'b000)) begin
                    res_next.temperature_centi = bsoc_pkg::TEMP_MAX;
                end else if (temp_full[21] && (temp_full[20:18] != 3'b111)) begin
                    res_next.temperature_centi = bsoc_pkg::TEMP_MIN;
                end else begin
                    res_next.temperature_centi = signed'(temp_full[18:0]);
                end
                offset_term_next = off_acc_reg;
                sens_term_next   = sens_acc_reg;
                terms_valid_next = 1'b1;
                step_next        = S_OUT;
            end
            S_P1: begin
                mul_a     = raw_op;
                mul_b     = sens_lo_op;
                step_next = S_P2;
            end
            S_P2: begin
                pacc_next = prod_ext;
                mul_a     = raw_op;
                mul_b     = sens_hi_op;
                step_next = S_P3;
            end
            S_P3: begin
                pacc_next = pacc_reg + prod_hi_shl;
                step_next = S_P4;
            end
            S_P4: begin
                x_next = signed'(pacc_sr[52:0])
                       - signed'({{5{offset_term_reg[47]}}, offset_term_reg});
                step_next = S_P5;
            end
            S_P5: begin
                if (!pres_full[52] && (pres_full[51:31] != '0)) begin
                    res_next.pressure_pa = bsoc_pkg::PRES_MAX;
                end else if (pres_full[52] && (pres_full[51:31] != '1)) begin
                    res_next.pressure_pa = bsoc_pkg::PRES_MIN;
                end else begin
                    res_next.pressure_pa = signed'(pres_full[31:0]);
                end
                step_next = S_OUT;
            end
            S_OUT: begin
                if (res_ready) begin
                    step_next = S_IDLE;
                end
            end
            default: begin
                step_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg        <= S_IDLE;
            terms_valid_reg <= 1'b0;
            offset_term_reg <= '0;
            sens_term_reg   <= '0;
        end else begin
            step_reg        <= step_next;
            terms_valid_reg <= terms_valid_next;
            offset_term_reg <= offset_term_next;
            sens_term_reg   <= sens_term_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        raw_reg      <= raw_next;
        dt_reg       <= dt_next;
        temp_reg     <= temp_next;
        t2_reg       <= t2_next;
        off_acc_reg  <= off_acc_next;
        sens_acc_reg <= sens_acc_next;
        pacc_reg     <= pacc_next;
        x_reg        <= x_next;
        res_reg      <= res_next;
    end

    assign in_ready  = (step_reg == S_IDLE);
    assign res_valid = (step_reg == S_OUT);
    assign res       = res_reg;

endmodule

`default_nettype wire

[rtl/baro_second_order_compensation.sv]
// Top level of the barometric second-order compensation block: configuration
// registers, the compute core and the output register. Uses bsoc_pkg and bsoc_core.
//
// Usage: raw conversion results enter on the s_ stream, one transfer per item, with
// s_tuser giving the kind (0 temperature, 1 pressure). Each item gives exactly one
// result transfer on the m_ stream carrying kind, status, temperature and pressure.
// Coefficients are written through cfg_we/cfg_addr/cfg_wdata; the user must write them
// only while the block is idle, as the block does not enforce it. Writes to indexes
// above five are ignored. One item is worked at a time on a single shared 26 by 26
// multiplier, one product per cycle. An invalid sample or a pressure sample without
// terms skips the multiplier; other samples run their multiply steps, a temperature
// sample with further steps below 20.00 C and again below -15.00 C. s_tready rises
// again in the cycle the result is loaded, so the next input can be taken while that
// result still waits for the receiver.
// When the receiver stalls, the finished result is held in the output register and a
// further finished item waits in the core until the register frees up.
// Reset clears the coefficients, the stored terms and their valid flag, and empties
// the output register.
`default_nettype none

module baro_second_order_compensation (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [23:0] raw_sample
    input  wire logic [0:0]  s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [18:0] temperature_centi, [50:19] pressure_pa
    output logic [2:0]       m_tuser,   // [0] sample_kind, [2:1] status
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    bsoc_pkg::cfg_t cfg_reg, cfg_next;
    bsoc_pkg::res_t m_res_reg, m_res_next;
    logic           m_valid_reg, m_valid_next;
    bsoc_pkg::res_t core_res;
    logic           core_res_valid;
    logic           core_res_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                bsoc_pkg::CFG_SENS_BASE:   cfg_next.sens_base   = cfg_wdata;
                bsoc_pkg::CFG_OFFSET_BASE: cfg_next.offset_base = cfg_wdata;
                bsoc_pkg::CFG_SENS_TEMP:   cfg_next.sens_temp   = cfg_wdata;
                bsoc_pkg::CFG_OFFSET_TEMP: cfg_next.offset_temp = cfg_wdata;
                bsoc_pkg::CFG_REF_TEMP:    cfg_next.ref_temp    = cfg_wdata;
                bsoc_pkg::CFG_TEMP_SLOPE:  cfg_next.temp_slope  = cfg_wdata;
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    bsoc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser[0]),
        .in_raw    (s_tdata),
        .cfg       (cfg_reg),
        .res_valid (core_res_valid),
        .res_ready (core_res_ready),
        .res       (core_res)
    );

    assign core_res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_res_next   = m_res_reg;
        m_valid_next = m_valid_reg;
        if (core_res_valid && core_res_ready) begin
            m_res_next   = core_res;
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_res_reg.pressure_pa, m_res_reg.temperature_centi};
    assign m_tuser  = {m_res_reg.status, m_res_reg.sample_kind};

endmodule

`default_nettype wire

[rtl/bsoc_checker.sv]
// Port-level checker for the barometric compensation block, bound to its top level.
// Depends on baro_second_order_compensation_macros.svh for the assertion macros.
`default_nettype none
`include "baro_second_order_compensation_macros.svh"

module bsoc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    `BSOC_ASSERT_NEXT(a_reset_empties_output, aclk, 1'b1, !aresetn, !m_tvalid, "output valid after reset")
    `BSOC_ASSERT_NEXT(a_busy_after_input, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while busy")
    `BSOC_ASSERT_SAME(a_status_legal, aclk, aresetn, m_tvalid, m_tuser[2:1] != 2'd3, "undefined status")
    `BSOC_ASSERT_SAME(a_temp_item_no_pressure, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[50:19] == 32'd0, "pressure on temperature item")
    `BSOC_ASSERT_NEXT(a_stalled_result_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind baro_second_order_compensation bsoc_checker u_bsoc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/bsoc_compensation_checker.sv]
// Checker for the barometric second-order compensation block: watches the input,
// result and coefficient ports, predicts each result and compares it field by field.
// Depends on bsoc_pkg for the result type, status codes and register indexes.
module bsoc_compensation_checker
    import bsoc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,
    input  wire logic [2:0]  m_tuser,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t   coeffs;
    longint stored_offset;
    longint stored_sens;
    logic   stored_valid;
    res_t   expected_readings[$];
    res_t   seen_reading;
    res_t   due_reading;
    int     mismatches = 0;
    int     waiting = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    task automatic report_mismatch(input string msg);
        if (mismatches < 100) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        mismatches++;
    endtask

    function automatic res_t compensate_sample(input logic kind, input logic [RAW_W-1:0] raw);
        res_t               r;
        longint             dt, temp, off, sens, t2, f, g, off2, sens2;
        logic signed [95:0] wide_raw, wide_sens, wide_off, x;
        r = '0;
        r.sample_kind = kind;
        if (raw == '0 || raw == RAW_ALL_ONES) begin
            r.status = STATUS_BAD_RAW;
            if (kind == KIND_TEMP) begin
                stored_offset = 0;
                stored_sens   = 0;
                stored_valid  = 1'b0;
            end
        end else if (kind == KIND_TEMP) begin
            r.status = STATUS_OK;
            dt   = longint'(raw) - (longint'(coeffs.ref_temp) << 8);
            temp = 2000 + ((dt * longint'(coeffs.temp_slope)) >>> 23);
            off  = (longint'(coeffs.offset_base) << 17)
                 + ((longint'(coeffs.offset_temp) * dt) >>> 6);
            sens = (longint'(coeffs.sens_base) << 16)
                 + ((longint'(coeffs.sens_temp) * dt) >>> 7);
            if (temp < 2000) begin
                t2    = (dt * dt) >>> 31;
                f     = (temp - 2000) * (temp - 2000);
                off2  = (61 * f) >>> 4;
                sens2 = 2 * f;
                if (temp < -1500) begin
                    g     = (temp + 1500) * (temp + 1500);
                    off2  = off2 + 15 * g;
                    sens2 = sens2 + 8 * g;
                end
                temp = temp - t2;
                off  = off - off2;
                sens = sens - sens2;
            end
            if (temp < -262144) begin
                temp = -262144;
            end else if (temp > 262143) begin
                temp = 262143;
            end
            r.temperature_centi = temp[18:0];
            stored_offset = off;
            stored_sens   = sens;
            stored_valid  = 1'b1;
        end else if (!stored_valid) begin
            r.status = STATUS_NO_TERMS;
        end else begin
            r.status  = STATUS_OK;
            wide_raw  = $signed({72'd0, raw});
            wide_sens = {{32{stored_sens[63]}}, stored_sens};
            wide_off  = {{32{stored_offset[63]}}, stored_offset};
            x = (((wide_raw * wide_sens) >>> 21) - wide_off) >>> 15;
            if (x > 96'sd2147483647) begin
                x = 96'sd2147483647;
            end else if (x < -96'sd2147483648) begin
                x = -96'sd2147483648;
            end
            r.pressure_pa = x[31:0];
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            coeffs        = '0;
            stored_offset = 0;
            stored_sens   = 0;
            stored_valid  = 1'b0;
            expected_readings.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen_reading.sample_kind       = m_tuser[0];
                seen_reading.status            = m_tuser[2:1];
                seen_reading.temperature_centi = m_tdata[18:0];
                seen_reading.pressure_pa       = m_tdata[50:19];
                if (m_tdata[55:51] != '0) begin
                    report_mismatch($sformatf("padding bits of m_tdata are %b", m_tdata[55:51]));
                end
                if (expected_readings.size() == 0) begin
                    report_mismatch("result transfer with no input waiting for it");
                end else begin
                    due_reading = expected_readings.pop_front();
                    if (seen_reading.sample_kind != due_reading.sample_kind) begin
                        report_mismatch($sformatf("sample_kind got %0d want %0d",
                            seen_reading.sample_kind, due_reading.sample_kind));
                    end
                    if (seen_reading.status != due_reading.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                            seen_reading.status, due_reading.status));
                    end
                    if (seen_reading.temperature_centi != due_reading.temperature_centi) begin
                        report_mismatch($sformatf("temperature_centi got %0d want %0d",
                            seen_reading.temperature_centi, due_reading.temperature_centi));
                    end
                    if (seen_reading.pressure_pa != due_reading.pressure_pa) begin
                        report_mismatch($sformatf("pressure_pa got %0d want %0d",
                            seen_reading.pressure_pa, due_reading.pressure_pa));
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_SENS_BASE:   coeffs.sens_base   = cfg_wdata;
                    CFG_OFFSET_BASE: coeffs.offset_base = cfg_wdata;
                    CFG_SENS_TEMP:   coeffs.sens_temp   = cfg_wdata;
                    CFG_OFFSET_TEMP: coeffs.offset_temp = cfg_wdata;
                    CFG_REF_TEMP:    coeffs.ref_temp    = cfg_wdata;
                    CFG_TEMP_SLOPE:  coeffs.temp_slope  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_readings.push_back(compensate_sample(s_tuser[0], s_tdata));
            end
        end
        waiting = expected_readings.size();
    end

endmodule

[tb/tb_top.sv]
// Top of the testbench for the barometric second-order compensation block: clock,
// reset, coefficient writes, sample stimulus, receiver back-pressure and the verdict.
// Depends on bsoc_pkg, the block itself and bsoc_compensation_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsoc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_STALL  = 300;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [RAW_W-1:0]  s_tdata = '0;
    logic [0:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [55:0]       m_tdata;
    logic [2:0]        m_tuser;
    logic              cfg_we = 1'b0;
    logic [2:0]        cfg_addr = '0;
    logic [15:0]       cfg_wdata = '0;

    int                fail_count;
    int                pending;
    int                cycle_count = 0;
    logic              src_idle_on = 1'b1;
    logic              sink_idle_on = 1'b1;
    logic              stall_req = 1'b0;
    logic              stall_seen = 1'b0;
    int                stall_left = 0;
    logic [COEFF_W-1:0] cur_ref = '0;

    baro_second_order_compensation DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    bsoc_compensation_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever begin
            #10 aclk = ~aclk;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (stall_req != stall_seen) begin
                stall_seen = stall_req;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(sink_idle_on && $urandom_range(99) < 15);
            end
        end
    end

    task automatic send_sample(input logic kind, input logic [RAW_W-1:0] raw);
        @(negedge aclk);
        while (src_idle_on && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= raw;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_coeff(input logic [CFG_ADDR_W-1:0] idx, input logic [COEFF_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
    endtask

    task automatic load_coeffs(input logic [COEFF_W-1:0] sens_base, offset_base, sens_temp,
                               offset_temp, ref_temp, temp_slope);
        write_coeff(CFG_SENS_BASE, sens_base);
        write_coeff(CFG_OFFSET_BASE, offset_base);
        write_coeff(CFG_SENS_TEMP, sens_temp);
        write_coeff(CFG_OFFSET_TEMP, offset_temp);
        write_coeff(CFG_REF_TEMP, ref_temp);
        write_coeff(CFG_TEMP_SLOPE, temp_slope);
        write_coeff($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom_range(65535)));
        @(negedge aclk);
        cfg_we <= 1'b0;
        cur_ref = ref_temp;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    function automatic logic [RAW_W-1:0] pick_raw(input bit near_ref);
        int sel, v;
        sel = $urandom_range(99);
        if (sel < 3) return '0;
        if (sel < 6) return RAW_ALL_ONES;
        if (near_ref && sel < 60) begin
            v = int'({8'd0, cur_ref, 8'd0}) + int'($urandom_range(4194304)) - 2097152;
            if (v < 1) v = 1;
            if (v > 16777214) v = 16777214;
            return v[RAW_W-1:0];
        end
        return RAW_W'($urandom_range(1, 16777214));
    endfunction

    task automatic run_burst(input int n_items);
        int sent, run_len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 8) begin
                send_sample(1'($urandom_range(1)), pick_raw(1'b0));
                sent++;
            end else begin
                send_sample(KIND_TEMP, pick_raw(1'b1));
                run_len = $urandom_range(1, 6);
                repeat (run_len) send_sample(KIND_PRES, pick_raw(1'b0));
                sent += run_len + 1;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        load_coeffs(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
        send_sample(KIND_PRES, 24'd6465444);
        send_sample(KIND_PRES, 24'd0);
        send_sample(KIND_TEMP, 24'd0);
        send_sample(KIND_TEMP, RAW_ALL_ONES);
        send_sample(KIND_PRES, RAW_ALL_ONES);
        send_sample(KIND_TEMP, 24'd8077568);
        send_sample(KIND_PRES, 24'd6465444);
        send_sample(KIND_PRES, 24'd1);
        send_sample(KIND_PRES, 24'hFFFFFE);
        send_sample(KIND_PRES, 24'h800000);
        send_sample(KIND_TEMP, 24'd8077567);
        send_sample(KIND_PRES, 24'd6465444);
        send_sample(KIND_TEMP, 24'd7035000);
        send_sample(KIND_PRES, 24'd6465444);
        send_sample(KIND_TEMP, 24'd1);
        send_sample(KIND_PRES, 24'd1);
        send_sample(KIND_PRES, 24'hFFFFFE);
        send_sample(KIND_TEMP, 24'hFFFFFE);
        send_sample(KIND_PRES, 24'd6465444);
        send_sample(KIND_TEMP, RAW_ALL_ONES);
        send_sample(KIND_PRES, 24'd6465444);
        send_sample(KIND_TEMP, 24'h555555);
        send_sample(KIND_PRES, 24'hAAAAAA);

        run_burst(200);
        // The receiver holds off while samples keep coming, so the block backs up.
        stall_req   = ~stall_req;
        src_idle_on = 1'b0;
        run_burst(40);
        src_idle_on = 1'b1;
        run_burst(100);
        wait_drained();
        run_burst(100);

        wait_drained();
        load_coeffs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_burst(250);

        wait_drained();
        load_coeffs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        run_burst(250);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;

        repeat (3) begin
            wait_drained();
            load_coeffs(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                        16'($urandom_range(65535)), 16'($urandom_range(65535)),
                        16'($urandom_range(65535)), 16'($urandom_range(65535)));
            run_burst(270);
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[baro_second_order_compensation.f]
+incdir+rtl
rtl/bsoc_pkg.sv
rtl/bsoc_mul.sv
rtl/bsoc_core.sv
rtl/baro_second_order_compensation.sv
rtl/bsoc_checker.sv
tb/bsoc_compensation_checker.sv
tb/tb_top.sv
